// File: hdl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and codes for the set-associative LRU cache tag block.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_STORE  = 2'd1;
   localparam logic [1:0] FUNC_MODIFY = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_OUT
   } back_state_type;

endpackage

// File: hdl/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front
// Accepts items, splits each address into set and tag, expands a modify into
// two accesses and queues them for the back end.
// ----------------------------------------------------------------------------
module salc_front import salc_pkg::*; #(
   parameter int SET_W  = 8,
   parameter int ADDR_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        func,
   input  logic [63:0]       address,
   input  logic [3:0]        eff_set_bits,
   input  logic [4:0]        eff_block_bits,
   output logic              acc_valid,
   input  logic              acc_take,
   output logic [SET_W-1:0]  acc_set,
   output logic [63:0]       acc_tag,
   output logic              acc_last
);

   localparam int ENTRY_W = SET_W + 64 + 1;

   logic [ENTRY_W-1:0] q_ff [2];
   logic [ENTRY_W-1:0] q_in [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic [63:0]        addr_m, shifted, tag_v;
   logic [SET_W-1:0]   set_v;
   logic               accept, two;
   logic [6:0]         sh;

   always_comb begin
      addr_m  = address & ({64{1'b1}} >> (64 - ADDR_W));
      shifted = addr_m >> eff_block_bits;
      set_v   = shifted[SET_W-1:0] & SET_W'(({SET_W{1'b1}} << eff_set_bits) ^ {SET_W{1'b1}});
      sh      = 7'(eff_set_bits) + 7'(eff_block_bits);
      tag_v   = addr_m >> sh;
      two     = (func == FUNC_MODIFY);
   end

   assign req_stall = (cnt_ff != 2'd0);
   assign accept    = req_valid && !req_stall;
   assign acc_valid = (cnt_ff != 2'd0);
   assign {acc_set, acc_tag, acc_last} = q_ff[0];

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (acc_take) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end
      if (accept) begin
         q_in[0] = {set_v, tag_v, !two};
         q_in[1] = {set_v, tag_v, 1'b1};
         cnt_in  = two ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      !(accept && acc_take)) else $error("accept while queue busy");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      !(acc_take && !acc_valid)) else $error("take from empty queue");

endmodule

// File: hdl/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back
// Reads one set, classifies hit, fill or eviction, writes the set back with
// updated ranks and counters, and holds the result for the output side.
// ----------------------------------------------------------------------------
module salc_back import salc_pkg::*; #(
   parameter int SET_W = 8,
   parameter int WAYS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             acc_valid,
   output logic             acc_take,
   input  logic [SET_W-1:0] acc_set,
   input  logic [63:0]      acc_tag,
   input  logic             acc_last,
   input  logic [3:0]       eff_ways,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       outcome,
   output logic [31:0]      hit_total,
   output logic [31:0]      miss_total,
   output logic [31:0]      eviction_total,
   output logic             last_of_item
);

   localparam int SETS = 1 << SET_W;
   localparam int RW   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LW   = 1 + 64 + RW;

   back_state_type state_ff, state_in;
   logic [WAYS*LW-1:0] mem [SETS];
   logic [WAYS*LW-1:0] rd_ff, wr_line;
   logic [SET_W-1:0]   clr_ff, clr_in, set_ff, wr_addr;
   logic [63:0]        tag_ff;
   logic               last_ff, we;
   logic [31:0]        hc_ff, mc_ff, ec_ff, hc_in, mc_in, ec_in;
   logic [1:0]         oc_ff, oc_in;

   logic [WAYS-1:0]    v;
   logic [63:0]        t [WAYS];
   logic [RW-1:0]      r [WAYS];
   logic [RW-1:0]      nr [WAYS];
   logic [WAYS-1:0]    nv;
   logic [63:0]        nt [WAYS];
   logic               hit, empty, found_v;
   logic [RW-1:0]      hit_w, emp_w, vic_w, ref_r, max_r, top_r, fill_r;
   logic               has_max;
   logic [RW:0]        fill_x;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         {v[i], t[i], r[i]} = rd_ff[i*LW +: LW];
      end
      hit = 1'b0; empty = 1'b0; found_v = 1'b0; has_max = 1'b0;
      hit_w = '0; emp_w = '0; vic_w = '0; max_r = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (i < int'(eff_ways)) begin
            if (v[i]) begin
               if (!hit && t[i] == tag_ff) begin hit = 1'b1; hit_w = RW'(i); end
               if (!has_max || r[i] > max_r) begin has_max = 1'b1; max_r = r[i]; end
               if (!found_v || r[i] < r[vic_w]) begin found_v = 1'b1; vic_w = RW'(i); end
            end else if (!empty) begin
               empty = 1'b1; emp_w = RW'(i);
            end
         end
      end
      top_r  = RW'(eff_ways - 4'd1);
      fill_x = has_max ? ({1'b0, max_r} + 1'b1) : '0;
      fill_r = (fill_x > {1'b0, top_r}) ? top_r : fill_x[RW-1:0];
      ref_r  = hit ? r[hit_w] : r[vic_w];
      for (int i = 0; i < WAYS; i++) begin
         nv[i] = v[i]; nt[i] = t[i]; nr[i] = r[i];
      end
      oc_in = OUT_HIT; hc_in = hc_ff; mc_in = mc_ff; ec_in = ec_ff;
      if (hit) begin
         hc_in = hc_ff + 32'd1;
         if (ref_r < max_r) begin
            for (int i = 0; i < WAYS; i++)
               if (i < int'(eff_ways) && v[i] && r[i] > ref_r) nr[i] = r[i] - 1'b1;
            nr[hit_w] = max_r;
         end
      end else if (empty) begin
         oc_in = OUT_FILL; mc_in = mc_ff + 32'd1;
         nv[emp_w] = 1'b1; nt[emp_w] = tag_ff; nr[emp_w] = fill_r;
      end else begin
         oc_in = OUT_EVICT; mc_in = mc_ff + 32'd1; ec_in = ec_ff + 32'd1;
         for (int i = 0; i < WAYS; i++)
            if (i < int'(eff_ways) && v[i] && r[i] > ref_r) nr[i] = r[i] - 1'b1;
         nt[vic_w] = tag_ff; nr[vic_w] = top_r;
      end
      for (int i = 0; i < WAYS; i++) wr_line[i*LW +: LW] = {nv[i], nt[i], nr[i]};
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      acc_take = 1'b0;
      we       = 1'b0;
      wr_addr  = set_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; wr_addr = clr_ff; clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc_valid) begin acc_take = 1'b1; state_in = ST_READ; end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin we = 1'b1; state_in = ST_OUT; end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (acc_valid) begin acc_take = 1'b1; state_in = ST_READ; end
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         hc_ff <= '0; mc_ff <= '0; ec_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == ST_UPDATE) begin
            hc_ff <= hc_in; mc_ff <= mc_in; ec_ff <= ec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= (state_ff == ST_CLEAR) ? '0 : wr_line;
      rd_ff <= mem[set_ff];
      if (acc_take) begin
         set_ff <= acc_set; tag_ff <= acc_tag; last_ff <= acc_last;
      end
      if (state_ff == ST_UPDATE) oc_ff <= oc_in;
   end

   assign rsp_valid      = (state_ff == ST_OUT);
   assign outcome        = oc_ff;
   assign hit_total      = hc_ff;
   assign miss_total     = mc_ff;
   assign eviction_total = ec_ff;
   assign last_of_item   = last_ff;

   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_UPDATE && !$past(state_ff == ST_READ)))
      else $error("update without read");
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      !(acc_take && state_ff != ST_IDLE && state_ff != ST_OUT))
      else $error("take in busy state");
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_OUT && oc_ff != OUT_HIT && oc_ff != OUT_FILL && oc_ff != OUT_EVICT))
      else $error("bad outcome code");

endmodule

// File: hdl/set_associative_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_associative_lru_cache_tags
// Tag, valid and LRU rank store of a set-associative cache with hit, miss and
// eviction counters.
// ----------------------------------------------------------------------------
// Each access passes through the back end as a set read, a set write-back and a
// result handoff, the handoff held while rsp_stall is high; a modify is two
// accesses. After reset the tag store is cleared at one set per cycle, MAX_SETS
// rounded up to a power of two sets, before the first item is taken. Reset
// again after changing configuration.
module set_associative_lru_cache_tags import salc_pkg::*; #(
   parameter int MAX_SETS  = 256,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_eviction_total,
   output logic        rsp_last_of_item,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int MAX_SB   = $clog2(MAX_SETS + 1) - 1;

   logic [3:0] set_bits_ff, ways_ff, eff_sb, eff_w;
   logic [4:0] block_bits_ff;
   logic             acc_valid, acc_take, acc_last;
   logic [SET_W-1:0] acc_set;
   logic [63:0]      acc_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 4'd4; block_bits_ff <= 5'd4; ways_ff <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[3:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            CSR_WAYS:       ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_sb = (int'(set_bits_ff) > MAX_SB) ? 4'(MAX_SB) : set_bits_ff;
      eff_w  = (ways_ff == 4'd0) ? 4'd1 :
               (int'(ways_ff) > MAX_WAYS) ? 4'(MAX_WAYS) : ways_ff;
   end

   salc_front #(.SET_W(SET_W), .ADDR_W(ADDR_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .func(req_func), .address(req_address),
      .eff_set_bits(eff_sb), .eff_block_bits(block_bits_ff),
      .acc_valid, .acc_take, .acc_set, .acc_tag, .acc_last
   );

   salc_back #(.SET_W(SET_W), .WAYS(MAX_WAYS)) u_back (
      .clock, .reset, .acc_valid, .acc_take, .acc_set, .acc_tag, .acc_last,
      .eff_ways(eff_w), .rsp_valid, .rsp_stall,
      .outcome(rsp_outcome), .hit_total(rsp_hit_total),
      .miss_total(rsp_miss_total), .eviction_total(rsp_eviction_total),
      .last_of_item(rsp_last_of_item)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag block: directed
// accesses, then random access streams under four configurations, each result
// checked against a behavioral tag/valid/rank model or a listed row outcome.
// ----------------------------------------------------------------------------
module tb;
   import salc_pkg::*;

   localparam int NUM_SETS   = 256;
   localparam int NUM_WAYS   = 8;
   localparam int LINES      = NUM_SETS * NUM_WAYS;
   localparam int CYCLE_CAP  = 2000000;
   localparam int PHASE_ITEMS = 320;
   localparam int NUM_ROWS   = 18;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
      logic        last;
   } access_result_type;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] address;
      bit          known;
      logic [1:0]  outcome;
   } access_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [63:0] req_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_outcome;
   logic [31:0] rsp_hit_total;
   logic [31:0] rsp_miss_total;
   logic [31:0] rsp_eviction_total;
   logic        rsp_last_of_item;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [4:0]  csr_data;

   set_associative_lru_cache_tags u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome), .rsp_hit_total(rsp_hit_total),
      .rsp_miss_total(rsp_miss_total), .rsp_eviction_total(rsp_eviction_total),
      .rsp_last_of_item(rsp_last_of_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // cache model state
   bit          line_valid [LINES];
   logic [63:0] line_tag   [LINES];
   logic [2:0]  line_rank  [LINES];
   logic [31:0] hit_count, miss_count, eviction_count;
   logic [3:0]  cfg_set_bits;
   logic [4:0]  cfg_block_bits;
   logic [3:0]  cfg_ways;

   access_result_type expected_results[$];
   int          error_count;
   int          accepted_items;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_request;
   bit          row_known;
   logic [1:0]  row_outcome;

   function automatic int set_bits_used();
      int s;
      s = int'(cfg_set_bits);
      while (s > 0 && (1 << s) > NUM_SETS) s--;
      return s;
   endfunction

   function automatic int ways_used();
      int e;
      e = int'(cfg_ways);
      if (e == 0) e = 1;
      if (e > NUM_WAYS) e = NUM_WAYS;
      return e;
   endfunction

   function automatic logic [1:0] cache_access(input logic [63:0] addr);
      int          s, b, e, base, k, hit, empty, victim, max_rank, r;
      logic [63:0] set_idx, tag;
      int          ref_rank;
      s = set_bits_used();
      b = int'(cfg_block_bits);
      e = ways_used();
      set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
      tag = addr >> (s + b);
      base = int'(set_idx) * NUM_WAYS;
      hit = -1; empty = -1; victim = -1; max_rank = -1;
      for (int i = 0; i < e; i++) begin
         k = base + i;
         if (line_valid[k]) begin
            if (hit < 0 && line_tag[k] == tag) hit = i;
            if (int'(line_rank[k]) > max_rank) max_rank = int'(line_rank[k]);
            if (victim < 0 || line_rank[k] < line_rank[base + victim]) victim = i;
         end else if (empty < 0) begin
            empty = i;
         end
      end
      if (hit >= 0) begin
         ref_rank = int'(line_rank[base + hit]);
         hit_count++;
         if (ref_rank < max_rank) begin
            for (int i = 0; i < e; i++)
               if (line_valid[base + i] && int'(line_rank[base + i]) > ref_rank)
                  line_rank[base + i]--;
            line_rank[base + hit] = 3'(max_rank);
         end
         return OUT_HIT;
      end
      miss_count++;
      if (empty >= 0) begin
         r = max_rank + 1;
         if (r > e - 1) r = e - 1;
         line_valid[base + empty] = 1'b1;
         line_tag[base + empty] = tag;
         line_rank[base + empty] = 3'(r);
         return OUT_FILL;
      end
      eviction_count++;
      ref_rank = int'(line_rank[base + victim]);
      for (int i = 0; i < e; i++)
         if (line_valid[base + i] && int'(line_rank[base + i]) > ref_rank)
            line_rank[base + i]--;
      line_tag[base + victim] = tag;
      line_rank[base + victim] = 3'(e - 1);
      return OUT_EVICT;
   endfunction

   function automatic void push_result(input logic [1:0] o, input logic last);
      access_result_type x;
      x.outcome = o;
      x.hits = hit_count;
      x.misses = miss_count;
      x.evictions = eviction_count;
      x.last = last;
      expected_results.push_back(x);
   endfunction

   initial begin
      clock = 0;
      cycle_count = 0;
      forever begin
         #5 clock = 1;
         cycle_count++;
         if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
         end
         #5 clock = 0;
      end
   end

   // accept items, apply register writes, check results
   always @(posedge clock) begin
      logic [1:0]        o;
      access_result_type x;
      if (!reset && csr_write) begin
         case (csr_index)
            CSR_SET_BITS:   cfg_set_bits <= csr_data[3:0];
            CSR_BLOCK_BITS: cfg_block_bits <= csr_data;
            CSR_WAYS:       cfg_ways <= csr_data[3:0];
            default: ;
         endcase
      end
      if (!reset && req_valid && !req_stall) begin
         accepted_items++;
         o = cache_access(req_address);
         if (row_known) o = row_outcome;
         if (req_func == FUNC_MODIFY) begin
            push_result(o, 1'b0);
            push_result(cache_access(req_address), 1'b1);
         end else begin
            push_result(o, 1'b1);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     {rsp_outcome, rsp_hit_total, rsp_miss_total,
                      rsp_eviction_total, rsp_last_of_item});
            error_count++;
         end else begin
            x = expected_results.pop_front();
            if (rsp_outcome !== x.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time, x.outcome,
                        rsp_outcome);
               error_count++;
            end
            if (rsp_hit_total !== x.hits) begin
               $display("%0t: hit_total expected %0d actual %0d", $time, x.hits,
                        rsp_hit_total);
               error_count++;
            end
            if (rsp_miss_total !== x.misses) begin
               $display("%0t: miss_total expected %0d actual %0d", $time, x.misses,
                        rsp_miss_total);
               error_count++;
            end
            if (rsp_eviction_total !== x.evictions) begin
               $display("%0t: eviction_total expected %0d actual %0d", $time,
                        x.evictions, rsp_eviction_total);
               error_count++;
            end
            if (rsp_last_of_item !== x.last) begin
               $display("%0t: last_of_item expected %0d actual %0d", $time, x.last,
                        rsp_last_of_item);
               error_count++;
            end
         end
      end
   end

   // receiver: random stall, with a long hold when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [63:0] addr,
                            input bit known, input logic [1:0] outcome);
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_address <= addr;
      row_known <= known;
      row_outcome <= outcome;
      n = accepted_items;
      do @(negedge clock); while (accepted_items == n);
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_results.size() != 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [4:0] s, input logic [4:0] b,
                            input logic [4:0] w);
      write_reg(CSR_SET_BITS, s);
      write_reg(CSR_BLOCK_BITS, b);
      write_reg(CSR_WAYS, w);
      @(negedge clock);
   endtask

   task automatic random_items(input int count);
      logic [1:0]  func;
      logic [63:0] addr;
      int          s, b;
      for (int i = 0; i < count; i++) begin
         s = set_bits_used();
         b = int'(cfg_block_bits);
         func = 2'($urandom_range(0, 3));
         if ($urandom_range(99) < 15) begin
            addr = {$urandom, $urandom};
         end else begin
            addr = 64'($urandom_range(0, 11)) << (s + b);
            if ($urandom_range(99) < 5) addr = addr | ({$urandom, $urandom} << 40);
            addr = addr | ((64'($urandom) & ((64'd1 << s) - 1)) << b);
            addr = addr | (64'($urandom) & ((64'd1 << b) - 1));
         end
         if (i == count / 3) hold_request = 300;
         if (i == count / 2) wait_empty();
         send_item(func, addr, 1'b0, OUT_HIT);
      end
      wait_empty();
   endtask

   access_row_type directed_rows [NUM_ROWS] = '{
      '{FUNC_LOAD,   64'h0,                  1, OUT_FILL},
      '{FUNC_STORE,  64'h0,                  1, OUT_HIT},
      '{FUNC_MODIFY, 64'h40,                 1, OUT_FILL},
      '{FUNC_SPARE,  64'h80,                 1, OUT_FILL},
      '{FUNC_LOAD,   64'hC0,                 1, OUT_FILL},
      '{FUNC_LOAD,   64'h100,                1, OUT_EVICT},
      '{FUNC_LOAD,   64'h0,                  0, OUT_HIT},
      '{FUNC_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1, OUT_FILL},
      '{FUNC_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 1, OUT_HIT},
      '{FUNC_LOAD,   64'h8000_0000_0000_0010, 1, OUT_FILL},
      '{FUNC_MODIFY, 64'h8000_0000_0000_0010, 0, OUT_HIT},
      '{FUNC_MODIFY, 64'h50,                 0, OUT_HIT},
      '{FUNC_STORE,  64'h90,                 0, OUT_HIT},
      '{FUNC_LOAD,   64'hD0,                 0, OUT_HIT},
      '{FUNC_LOAD,   64'h110,                0, OUT_HIT},
      '{FUNC_STORE,  64'h50,                 0, OUT_HIT},
      '{FUNC_SPARE,  64'h7FFF_FFFF_FFFF_FFEF, 0, OUT_HIT},
      '{FUNC_MODIFY, 64'h0,                  0, OUT_HIT}
   };

   initial begin
      error_count = 0;
      accepted_items = 0;
      hold_request = 0;
      send_idle_pct = 25;
      recv_idle_pct = 62;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LOAD;
      req_address = '0;
      csr_write = 1'b0;
      csr_index = CSR_SET_BITS;
      csr_data = '0;
      row_known = 1'b0;
      row_outcome = OUT_HIT;
      cfg_set_bits = 4'd4;
      cfg_block_bits = 5'd4;
      cfg_ways = 4'd1;
      hit_count = '0;
      miss_count = '0;
      eviction_count = '0;
      for (int i = 0; i < LINES; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i] = '0;
         line_rank[i] = '0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      configure(5'd2, 5'd4, 5'd4);
      foreach (directed_rows[i])
         send_item(directed_rows[i].func, directed_rows[i].address,
                   directed_rows[i].known, directed_rows[i].outcome);
      wait_empty();
      random_items(PHASE_ITEMS);

      send_idle_pct = 62;
      recv_idle_pct = 25;
      configure(5'd15, 5'd31, 5'd15);
      random_items(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(5'd0, 5'd0, 5'd0);
      random_items(PHASE_ITEMS);

      configure(5'd8, 5'd16, 5'd8);
      random_items(PHASE_ITEMS);

      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/salc_pkg.sv
hdl/salc_front.sv
hdl/salc_back.sv
hdl/set_associative_lru_cache_tags.sv
bench/tb.sv
